// ===== rtl/core/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants, microcode table and saturation helpers for the
// PID controller with back-calculation anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int ProdW   = 2 * DataW;
  localparam int SumW    = DataW + 2;
  localparam int StepW   = 3;
  localparam int RegIdxW = 3;
  localparam int AddrW   = 5;
  localparam int TsW     = 17;
  localparam int ItsW    = 31;
  localparam int LimW    = 31;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // register map, one 32-bit word per register
  localparam logic [RegIdxW-1:0] REG_ENABLE    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_GAIN_BACK = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TS        = 3'd5;
  localparam logic [RegIdxW-1:0] REG_INV_TS    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SAT_LIMIT = 3'd7;

  localparam logic [StepW-1:0] STEP_FIRST  = 3'd0;
  localparam logic [StepW-1:0] STEP_FINISH = 3'd7;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KB_WF,
    MUL_DT_ITS,
    MUL_KI_T,
    MUL_TS_IPI,
    MUL_KP_E,
    MUL_KD_DT
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_DIFF,
    ALU_ADD_E_Q,
    ALU_Q_TO_DT,
    ALU_Q_TO_IIN,
    ALU_ACC_UPD,
    ALU_SUM_INIT,
    ALU_SUM_ADD,
    ALU_FINISH
  } alu_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    logic     skip_if_kd_zero;
    logic     last;
  } ucode_t;

  typedef struct packed {
    word_t             gain_p;
    word_t             gain_i;
    word_t             gain_d;
    word_t             gain_back;
    logic [TsW-1:0]    sample_period;
    logic [ItsW-1:0]   inv_sample_period;
    logic [LimW-1:0]   sat_limit;
  } cfg_t;

  typedef struct packed {
    ucode_t uc;
    logic   load;      // latch a new error sample
    logic   advance;   // current control word executes this cycle
    logic   disabled;  // request taken while disabled: give zero, keep state
  } dp_ctrl_t;

  // The program. prod_r of each step holds the product issued by the step executed before it.
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uc;
    uc = '{mul_sel: MUL_NONE, alu_op: ALU_NOP, skip_if_kd_zero: 1'b0, last: 1'b0};
    unique case (step)
      3'd0: uc = '{MUL_KB_WF,  ALU_DIFF,     1'b0, 1'b0};
      3'd1: uc = '{MUL_DT_ITS, ALU_ADD_E_Q,  1'b0, 1'b0};
      3'd2: uc = '{MUL_KI_T,   ALU_Q_TO_DT,  1'b0, 1'b0};
      3'd3: uc = '{MUL_TS_IPI, ALU_Q_TO_IIN, 1'b0, 1'b0};
      3'd4: uc = '{MUL_KP_E,   ALU_ACC_UPD,  1'b0, 1'b0};
      3'd5: uc = '{MUL_KD_DT,  ALU_SUM_INIT, 1'b1, 1'b0};
      3'd6: uc = '{MUL_NONE,   ALU_SUM_ADD,  1'b0, 1'b0};
      3'd7: uc = '{MUL_NONE,   ALU_FINISH,   1'b0, 1'b1};
    endcase
    return uc;
  endfunction

  // saturate a wide sum to the data range
  function automatic word_t sat_sum(input sum_t x);
    logic [SumW-DataW:0] top;
    top = x[SumW-1:DataW-1];
    if ((&top) || !(|top)) return x[DataW-1:0];
    else if (x[SumW-1]) return {1'b1, {(DataW-1){1'b0}}};
    else return {1'b0, {(DataW-1){1'b1}}};
  endfunction

  // drop the fraction (floor) and saturate to the data range
  function automatic word_t sat_prod(input prod_t p);
    prod_t                sh;
    logic [ProdW-DataW:0] top;
    sh  = p >>> FracW;
    top = sh[ProdW-1:DataW-1];
    if ((&top) || !(|top)) return sh[DataW-1:0];
    else if (sh[ProdW-1]) return {1'b1, {(DataW-1){1'b0}}};
    else return {1'b0, {(DataW-1){1'b1}}};
  endfunction

endpackage

// ===== rtl/core/pid_antiwindup_controller.sv =====
// ----------------------------------------------------------------------------
// pid_antiwindup_controller
// Discrete PID with back-calculation anti-windup, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write gains, sample period, its reciprocal and the limit over the APB
//   port (word per register at 4*index), then set enable. Each request on
//   the in_ channel carries one error sample; each gives one request on the
//   out_ channel with the clamped drive and a clamped flag.
//   A microcode sequencer steps a single 32x32 multiplier and one adder
//   through a fixed eight-word program. An enabled sample runs the whole
//   program (the derivative step is skipped when gain_d is zero); a
//   disabled sample goes straight to the last step. The output register
//   loads as the last step ends. in_stall is high while the program runs,
//   so a new sample is taken only once the previous one has left it.
//   When out_stall holds a result, the last step waits until the output
//   register frees; a new sample is still taken while a result waits.
//   Reset clears all configuration (limit to its maximum), the controller
//   state, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pidaw_pkg::DataW-1:0] in_error_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pidaw_pkg::DataW-1:0] out_drive,
  output logic                              out_clamped,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic                       enable_r;
  pidaw_pkg::cfg_t            cfg_r;
  logic [pidaw_pkg::RegIdxW-1:0] reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pidaw_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      cfg_r    <= '{gain_p: '0, gain_i: '0, gain_d: '0, gain_back: '0,
                    sample_period: '0, inv_sample_period: '0, sat_limit: '1};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pidaw_pkg::REG_ENABLE:    enable_r                <= pwdata[0];
        pidaw_pkg::REG_GAIN_P:    cfg_r.gain_p            <= pwdata;
        pidaw_pkg::REG_GAIN_I:    cfg_r.gain_i            <= pwdata;
        pidaw_pkg::REG_GAIN_D:    cfg_r.gain_d            <= pwdata;
        pidaw_pkg::REG_GAIN_BACK: cfg_r.gain_back         <= pwdata;
        pidaw_pkg::REG_TS:        cfg_r.sample_period     <= pwdata[pidaw_pkg::TsW-1:0];
        pidaw_pkg::REG_INV_TS:    cfg_r.inv_sample_period <= pwdata[pidaw_pkg::ItsW-1:0];
        pidaw_pkg::REG_SAT_LIMIT: cfg_r.sat_limit         <= pwdata[pidaw_pkg::LimW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pidaw_pkg::REG_ENABLE:    prdata = {31'b0, enable_r};
      pidaw_pkg::REG_GAIN_P:    prdata = cfg_r.gain_p;
      pidaw_pkg::REG_GAIN_I:    prdata = cfg_r.gain_i;
      pidaw_pkg::REG_GAIN_D:    prdata = cfg_r.gain_d;
      pidaw_pkg::REG_GAIN_BACK: prdata = cfg_r.gain_back;
      pidaw_pkg::REG_TS:        prdata = {15'b0, cfg_r.sample_period};
      pidaw_pkg::REG_INV_TS:    prdata = {1'b0, cfg_r.inv_sample_period};
      pidaw_pkg::REG_SAT_LIMIT: prdata = {1'b0, cfg_r.sat_limit};
    endcase
  end

  // sequencer
  pidaw_pkg::seq_state_t          state_r, state_nxt;
  logic [pidaw_pkg::StepW-1:0]    step_r, step_nxt;
  logic                           dis_r, dis_nxt;
  pidaw_pkg::ucode_t              uc;
  pidaw_pkg::dp_ctrl_t            ctrl;
  logic                           in_acc;
  logic                           advance;
  logic                           finish_fire;
  logic                           kd_zero;

  pidaw_pkg::word_t               res_drive;
  logic                           res_clamped;

  logic                           out_valid_r, out_valid_nxt;
  pidaw_pkg::word_t               drive_r;
  logic                           clamped_r;

  assign uc          = pidaw_pkg::ucode_rom(step_r);
  assign in_acc      = in_valid && !in_stall;
  assign kd_zero     = (cfg_r.gain_d == '0);
  // hold the last step while the output register is still occupied
  assign advance     = (state_r == pidaw_pkg::SEQ_RUN) &&
                       !(uc.last && out_valid_r && out_stall);
  assign finish_fire = advance && uc.last;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dis_nxt   = dis_r;
    unique case (state_r)
      pidaw_pkg::SEQ_IDLE: begin
        if (in_acc) begin
          state_nxt = pidaw_pkg::SEQ_RUN;
          dis_nxt   = !enable_r;
          step_nxt  = enable_r ? pidaw_pkg::STEP_FIRST : pidaw_pkg::STEP_FINISH;
        end
      end
      pidaw_pkg::SEQ_RUN: begin
        if (advance) begin
          if (uc.last) state_nxt = pidaw_pkg::SEQ_IDLE;
          else if (uc.skip_if_kd_zero && kd_zero) step_nxt = pidaw_pkg::STEP_FINISH;
          else step_nxt = step_r + 1'b1;
        end
      end
      default: state_nxt = pidaw_pkg::SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = (state_r != pidaw_pkg::SEQ_IDLE);
    ctrl.uc       = uc;
    ctrl.load     = in_acc;
    ctrl.advance  = advance;
    ctrl.disabled = dis_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidaw_pkg::SEQ_IDLE;
      step_r  <= pidaw_pkg::STEP_FIRST;
      dis_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dis_r   <= dis_nxt;
    end
  end

  pidaw_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .ctrl        (ctrl),
    .error_in    (in_error_in),
    .res_drive   (res_drive),
    .res_clamped (res_clamped)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (finish_fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      drive_r   <= res_drive;
      clamped_r <= res_clamped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;

endmodule

// ===== rtl/core/pidaw_datapath.sv =====
// ----------------------------------------------------------------------------
// pidaw_datapath
// Multiplier, adder and controller state, driven one control word per cycle while the sequencer advances.
// ----------------------------------------------------------------------------
module pidaw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pidaw_pkg::cfg_t     cfg,
  input  pidaw_pkg::dp_ctrl_t ctrl,
  input  pidaw_pkg::word_t    error_in,
  output pidaw_pkg::word_t    res_drive,
  output logic                res_clamped
);

  pidaw_pkg::word_t e_r,   e_nxt;
  pidaw_pkg::word_t t_r,   t_nxt;
  pidaw_pkg::word_t dt_r,  dt_nxt;
  pidaw_pkg::word_t iin_r, iin_nxt;
  pidaw_pkg::prod_t prod_r, prod_nxt;
  pidaw_pkg::sum_t  sum_r, sum_nxt;

  pidaw_pkg::word_t wf_r,   wf_nxt;
  pidaw_pkg::word_t acc_r,  acc_nxt;
  pidaw_pkg::word_t ipi_r,  ipi_nxt;
  pidaw_pkg::word_t prev_r, prev_nxt;

  pidaw_pkg::word_t mul_a, mul_b;
  pidaw_pkg::word_t q;
  pidaw_pkg::word_t u, us, lim_pos, lim_neg;
  logic             kd_zero;

  assign q       = pidaw_pkg::sat_prod(prod_r);
  assign kd_zero = (cfg.gain_d == '0);
  assign lim_pos = pidaw_pkg::word_t'({1'b0, cfg.sat_limit});
  assign lim_neg = -lim_pos;

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.uc.mul_sel)
      pidaw_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      pidaw_pkg::MUL_KB_WF: begin
        mul_a = cfg.gain_back;
        mul_b = wf_r;
      end
      pidaw_pkg::MUL_DT_ITS: begin
        mul_a = dt_r;
        mul_b = pidaw_pkg::word_t'({1'b0, cfg.inv_sample_period});
      end
      pidaw_pkg::MUL_KI_T: begin
        mul_a = cfg.gain_i;
        mul_b = t_r;
      end
      pidaw_pkg::MUL_TS_IPI: begin
        mul_a = pidaw_pkg::word_t'({{(pidaw_pkg::DataW-pidaw_pkg::TsW){1'b0}},
                                    cfg.sample_period});
        mul_b = ipi_r;
      end
      pidaw_pkg::MUL_KP_E: begin
        mul_a = cfg.gain_p;
        mul_b = e_r;
      end
      pidaw_pkg::MUL_KD_DT: begin
        mul_a = cfg.gain_d;
        mul_b = dt_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // output clamp from the accumulated sum
  always_comb begin
    u = pidaw_pkg::sat_sum(sum_r);
    if (!u[pidaw_pkg::DataW-1]) us = (u > lim_pos) ? lim_pos : u;
    else                        us = (u < lim_neg) ? lim_neg : u;
    res_drive   = ctrl.disabled ? '0 : us;
    res_clamped = ctrl.disabled ? 1'b0 : (us != u);
  end

  always_comb begin
    e_nxt    = ctrl.load ? error_in : e_r;
    t_nxt    = t_r;
    dt_nxt   = dt_r;
    iin_nxt  = iin_r;
    prod_nxt = prod_r;
    sum_nxt  = sum_r;
    wf_nxt   = wf_r;
    acc_nxt  = acc_r;
    ipi_nxt  = ipi_r;
    prev_nxt = prev_r;
    if (ctrl.advance) begin
      prod_nxt = mul_a * mul_b;
      unique case (ctrl.uc.alu_op)
        pidaw_pkg::ALU_NOP: ;
        pidaw_pkg::ALU_DIFF:
          dt_nxt = pidaw_pkg::sat_sum(pidaw_pkg::sum_t'(e_r) - pidaw_pkg::sum_t'(prev_r));
        pidaw_pkg::ALU_ADD_E_Q:
          t_nxt = pidaw_pkg::sat_sum(pidaw_pkg::sum_t'(e_r) + pidaw_pkg::sum_t'(q));
        pidaw_pkg::ALU_Q_TO_DT:  dt_nxt  = q;
        pidaw_pkg::ALU_Q_TO_IIN: iin_nxt = q;
        pidaw_pkg::ALU_ACC_UPD: begin
          acc_nxt = pidaw_pkg::sat_sum(pidaw_pkg::sum_t'(acc_r) + pidaw_pkg::sum_t'(q));
          ipi_nxt = iin_r;
        end
        pidaw_pkg::ALU_SUM_INIT:
          sum_nxt = pidaw_pkg::sum_t'(acc_r) + pidaw_pkg::sum_t'(q);
        pidaw_pkg::ALU_SUM_ADD:
          sum_nxt = sum_r + pidaw_pkg::sum_t'(q);
        pidaw_pkg::ALU_FINISH: begin
          if (!ctrl.disabled) begin
            wf_nxt = pidaw_pkg::sat_sum(pidaw_pkg::sum_t'(us) - pidaw_pkg::sum_t'(u));
            if (!kd_zero) prev_nxt = e_r;
          end
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    t_r    <= t_nxt;
    dt_r   <= dt_nxt;
    iin_r  <= iin_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r   <= '0;
      acc_r  <= '0;
      ipi_r  <= '0;
      prev_r <= '0;
    end else begin
      wf_r   <= wf_nxt;
      acc_r  <= acc_nxt;
      ipi_r  <= ipi_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

// ===== rtl/core/pidaw_checker.sv =====
// ----------------------------------------------------------------------------
// pidaw_checker
// Port-level checks on the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidaw_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [pidaw_pkg::DataW-1:0] out_drive,
  input logic                               out_clamped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_clamped))
    else $error("stalled result changed");

  // sequencer is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while not busy afterwards");

  // no result appears in the cycle right after a request
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // a new result only follows a busy cycle
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a running program");

endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_drive   (out_drive),
  .out_clamped (out_clamped)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the PID controller with back-calculation anti-windup against a
// cycle-free predictor of the Q16.16 control law. Directed samples cover
// reset defaults, clamping, rounding, the derivative-off case, extreme gains,
// a zero limit and the disabled state. Random phases then reprogram every
// register and stream error samples, with request gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pidaw_pkg::word_t drive;
    logic             clamped;
  } drive_result_t;

  localparam pidaw_pkg::word_t ONE = 32'sd65536;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  pidaw_pkg::word_t            in_error_in;
  logic                        out_valid;
  logic                        out_stall;
  pidaw_pkg::word_t            out_drive;
  logic                        out_clamped;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [pidaw_pkg::AddrW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  // settings the block should hold
  logic                        ctl_enable;
  pidaw_pkg::word_t            ctl_kp, ctl_ki, ctl_kd, ctl_kb;
  logic [pidaw_pkg::TsW-1:0]   ctl_ts;
  logic [pidaw_pkg::ItsW-1:0]  ctl_its;
  logic [pidaw_pkg::LimW-1:0]  ctl_lim;
  // loop state
  pidaw_pkg::word_t            st_windup, st_acc, st_int_in, st_prev_err;

  drive_result_t     pending_drives[$];
  int                mismatches = 0;
  bit                quiet = 1'b0;

  pid_antiwindup_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_error_in (in_error_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .out_clamped (out_clamped),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic pidaw_pkg::word_t fx_clip(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return pidaw_pkg::word_t'(x[31:0]);
  endfunction

  // floor of the Q16.16 product, saturated
  function automatic pidaw_pkg::word_t fx_mul(input pidaw_pkg::word_t a,
                                              input pidaw_pkg::word_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return fx_clip(prod >>> pidaw_pkg::FracW);
  endfunction

  function automatic drive_result_t predict_drive(input pidaw_pkg::word_t e);
    pidaw_pkg::word_t p, iin, d, u;
    longint           lim, us;
    drive_result_t    r;
    r = '{drive: '0, clamped: 1'b0};
    if (!ctl_enable) return r;
    d   = '0;
    p   = fx_mul(ctl_kp, e);
    iin = fx_mul(ctl_ki, fx_clip(longint'(e) + longint'(fx_mul(ctl_kb, st_windup))));
    st_acc = fx_clip(longint'(st_acc)
                     + longint'(fx_mul(pidaw_pkg::word_t'({15'd0, ctl_ts}),
                                       st_int_in)));
    st_int_in = iin;
    // derivative path and its memory only run with a nonzero gain
    if (ctl_kd != 0) begin
      d = fx_mul(ctl_kd, fx_mul(fx_clip(longint'(e) - longint'(st_prev_err)),
                                pidaw_pkg::word_t'({1'b0, ctl_its})));
      st_prev_err = e;
    end
    u   = fx_clip(longint'(p) + longint'(st_acc) + longint'(d));
    lim = longint'({1'b0, ctl_lim});
    us  = longint'(u);
    if (us > lim) us = lim;
    else if (us < -lim) us = -lim;
    st_windup = fx_clip(us - longint'(u));
    r.drive   = pidaw_pkg::word_t'(us[31:0]);
    r.clamped = (us != longint'(u));
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t unexpected result: drive %0d clamped %0b",
                   $time, out_drive, out_clamped);
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t drive mismatch: expected %0d, actual %0d",
                     $time, want.drive, out_drive);
        end
        if (out_clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t clamped mismatch: expected %0b, actual %0b",
                     $time, want.clamped, out_clamped);
        end
      end
    end
  end

  // result side back-pressure: mostly short bursts, now and then a long hold
  initial begin : result_backpressure
    int   hold;
    int   r;
    logic level;
    hold      = 0;
    level     = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        hold = 0;
        out_stall <= 1'b0;
      end else begin
        if (hold == 0) begin
          r = $urandom_range(0, 99);
          if (r < 60) begin
            level = 1'b0;
            hold  = $urandom_range(1, 8);
          end else if (r < 94) begin
            level = 1'b1;
            hold  = $urandom_range(1, 3);
          end else begin
            level = 1'b1;
            hold  = $urandom_range(15, 50);
          end
        end
        hold--;
        out_stall <= level;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // all driver tasks start and end just after a falling edge
  task automatic send_error(input pidaw_pkg::word_t err);
    int gap;
    in_valid    <= 1'b1;
    in_error_in <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drives.push_back(predict_drive(err));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [pidaw_pkg::RegIdxW-1:0] idx,
                           input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pidaw_pkg::REG_ENABLE:    ctl_enable = data[0];
      pidaw_pkg::REG_GAIN_P:    ctl_kp     = data;
      pidaw_pkg::REG_GAIN_I:    ctl_ki     = data;
      pidaw_pkg::REG_GAIN_D:    ctl_kd     = data;
      pidaw_pkg::REG_GAIN_BACK: ctl_kb     = data;
      pidaw_pkg::REG_TS:        ctl_ts     = data[pidaw_pkg::TsW-1:0];
      pidaw_pkg::REG_INV_TS:    ctl_its    = data[pidaw_pkg::ItsW-1:0];
      pidaw_pkg::REG_SAT_LIMIT: ctl_lim    = data[pidaw_pkg::LimW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // drop the request, then hold off until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] en, kp, ki, kd, kb, ts, its, lim);
    wait_idle();
    write_reg(pidaw_pkg::REG_ENABLE, en);
    write_reg(pidaw_pkg::REG_GAIN_P, kp);
    write_reg(pidaw_pkg::REG_GAIN_I, ki);
    write_reg(pidaw_pkg::REG_GAIN_D, kd);
    write_reg(pidaw_pkg::REG_GAIN_BACK, kb);
    write_reg(pidaw_pkg::REG_TS, ts);
    write_reg(pidaw_pkg::REG_INV_TS, its);
    write_reg(pidaw_pkg::REG_SAT_LIMIT, lim);
  endtask

  // ---------------------------------------------------------------- random values

  function automatic pidaw_pkg::word_t rand_span(input int unsigned span);
    return pidaw_pkg::word_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // occasionally set bits the register does not keep
  function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] keep);
    if ($urandom_range(0, 9) == 0) return v | ($urandom() & ~keep);
    return v;
  endfunction

  function automatic pidaw_pkg::word_t pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    if (r < 80) return rand_span(1 << 18);
    return pidaw_pkg::word_t'($urandom());
  endfunction

  function automatic logic [31:0] pick_unsigned(input logic [31:0] top,
                                                input logic [31:0] typical);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return top;
    if (r < 80) return $urandom_range(1, typical);
    return $urandom() & top;
  endfunction

  function automatic pidaw_pkg::word_t pick_error();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh7FFF_FFFF;
    if (r < 6) return 32'sh8000_0000;
    if (r < 9) return pidaw_pkg::word_t'(int'($urandom_range(0, 2)) - 1);
    if (r < 55) return rand_span(1 << 22);
    if (r < 80) return rand_span(1 << 17);
    return pidaw_pkg::word_t'($urandom());
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_after_reset();
    // reset leaves the controller disabled
    send_error(32'sh7FFF_FFFF);
    send_error(32'sh8000_0000);
  endtask

  task automatic test_nominal();
    load_settings(1, ONE, ONE / 2, ONE / 4, ONE, 655, 100 * ONE, 5 * ONE);
    send_error(0);
    send_error(ONE);
    send_error(3 * ONE);
    send_error(10 * ONE);
    send_error(-10 * ONE);
    send_error(-1);
    send_error(1);
  endtask

  task automatic test_no_derivative();
    load_settings(1, ONE, ONE / 2, 0, ONE, 655, 100 * ONE, 5 * ONE);
    send_error(2 * ONE);
    send_error(-2 * ONE);
    send_error(2 * ONE);
  endtask

  task automatic test_extremes();
    load_settings(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0001_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_error(32'sh7FFF_FFFF);
    send_error(32'sh8000_0000);
    send_error(32'sh8000_0000);
    send_error(32'sh7FFF_FFFF);
  endtask

  task automatic test_zero_limit();
    load_settings(1, ONE, ONE, ONE, ONE / 2, 6554, 10 * ONE, 0);
    send_error(ONE);
    send_error(-ONE);
    send_error(0);
  endtask

  task automatic test_disabled();
    // state must survive a disabled stretch
    wait_idle();
    write_reg(pidaw_pkg::REG_ENABLE, 0);
    send_error(5 * ONE);
    send_error(-5 * ONE);
    wait_idle();
    write_reg(pidaw_pkg::REG_ENABLE, 1);
    send_error(ONE);
    send_error(0);
  endtask

  task automatic test_random_sweep();
    pidaw_pkg::word_t err;
    int               held;
    for (int ph = 0; ph < 21; ph++) begin
      load_settings(with_junk({31'd0, $urandom_range(0, 99) < 85}, 32'h1),
                    pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                    with_junk(pick_unsigned(32'h0001_FFFF, 6554), 32'h0001_FFFF),
                    with_junk(pick_unsigned(32'h7FFF_FFFF, 100 * ONE), 32'h7FFF_FFFF),
                    with_junk(pick_unsigned(32'h7FFF_FFFF, 50 * ONE), 32'h7FFF_FFFF));
      quiet = (ph % 4 == 3);
      held  = 0;
      for (int k = 0; k < 80; k++) begin
        // odd phases hold each error for a while, like a stepped setpoint
        if (held == 0) begin
          err  = pick_error();
          held = (ph % 2 == 1) ? $urandom_range(1, 10) : 1;
        end
        held--;
        send_error(err);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_error_in = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    ctl_enable  = 1'b0;
    ctl_kp      = '0;
    ctl_ki      = '0;
    ctl_kd      = '0;
    ctl_kb      = '0;
    ctl_ts      = '0;
    ctl_its     = '0;
    ctl_lim     = '1;
    st_windup   = '0;
    st_acc      = '0;
    st_int_in   = '0;
    st_prev_err = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_nominal();
    test_no_derivative();
    test_extremes();
    test_zero_limit();
    test_disabled();
    test_random_sweep();

    wait_idle();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_datapath.sv
rtl/core/pid_antiwindup_controller.sv
rtl/core/pidaw_checker.sv
bench/testbench.sv
